/* src/labf_pkg.sv */
// labf_pkg: shared widths, constants and payload types for the lidar
// angular-bin minimum-range filter. No dependencies.
`timescale 1ns / 1ps

package labf_pkg;

  // field widths
  localparam int unsigned FieldW = 15;
  localparam int unsigned BprW   = 13;
  localparam int unsigned BinW   = 16;

  // bearing fixed point: 1/2^AngleFracBits rad per LSB
  localparam int unsigned AngleFracBits = 12;

  // bearing * bins_per_radian, signed, exact
  localparam int unsigned ProdW = FieldW + BprW;

  // configuration port
  localparam int unsigned PdataW  = 32;
  localparam int unsigned PaddrW  = 2;
  localparam logic [PaddrW-1:0] RegBprAddr = PaddrW'(0);
  localparam logic [BprW-1:0]   BprReset   = BprW'(100);

  // result queue
  localparam int unsigned OutDepth = 4;
  localparam int unsigned PtrW     = $clog2(OutDepth);

  typedef logic signed [FieldW-1:0] coord_t;
  typedef logic        [BinW-1:0]   bin_t;

  typedef struct packed {
    coord_t            point_x;
    coord_t            point_y;
    coord_t            bearing;
    logic [FieldW-1:0] distance;
    logic              last_point;
  } point_t;

  typedef struct packed {
    coord_t kept_x;
    coord_t kept_y;
    coord_t kept_bearing;
    logic   scan_done;
  } kept_t;

  // up to two results per point, both written to the queue in the same cycle
  typedef struct packed {
    logic  first_vld;
    logic  second_vld;
    kept_t first;
    kept_t second;
  } res_push_t;

endpackage

/* src/labf_if.sv */
// labf_point_if / labf_kept_if: valid/ready channels for points and kept results.
// Depends on labf_pkg.
`timescale 1ns / 1ps

interface labf_point_if;
  import labf_pkg::*;

  logic              valid;
  logic              ready;
  coord_t            point_x;
  coord_t            point_y;
  coord_t            bearing;
  logic [FieldW-1:0] distance;
  logic              last_point;

  modport source (
    output valid, point_x, point_y, bearing, distance, last_point,
    input  ready
  );
  modport sink (
    input  valid, point_x, point_y, bearing, distance, last_point,
    output ready
  );
endinterface

interface labf_kept_if;
  import labf_pkg::*;

  logic   valid;
  logic   ready;
  coord_t kept_x;
  coord_t kept_y;
  coord_t kept_bearing;
  logic   scan_done;

  modport source (
    output valid, kept_x, kept_y, kept_bearing, scan_done,
    input  ready
  );
  modport sink (
    input  valid, kept_x, kept_y, kept_bearing, scan_done,
    output ready
  );
endinterface

/* src/labf_cfg_regs.sv */
// labf_cfg_regs: APB-style register file holding bins_per_radian.
// Depends on labf_pkg.
`timescale 1ns / 1ps

module labf_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [labf_pkg::PaddrW-1:0]  paddr,
  input  logic [labf_pkg::PdataW-1:0]  pwdata,
  output logic [labf_pkg::PdataW-1:0]  prdata,
  output logic                         pready,
  output logic [labf_pkg::BprW-1:0]    bpr_o
);
  import labf_pkg::*;

  logic [BprW-1:0] bpr_q;
  logic            wr_bpr;

  // no wait states
  assign pready = 1'b1;
  assign wr_bpr = psel && penable && pwrite && (paddr == RegBprAddr);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpr_q <= BprReset;
    end else if (wr_bpr) begin
      bpr_q <= pwdata[BprW-1:0];
    end
  end

  // read mux
  always_comb begin
    prdata = '0;
    if (paddr == RegBprAddr) begin
      prdata = PdataW'(bpr_q);
    end
  end

  assign bpr_o = bpr_q;

endmodule

/* src/labf_result_fifo.sv */
// labf_result_fifo: small result queue, takes up to two results per cycle and
// drives the kept-point channel. Depends on labf_pkg and labf_kept_if.
`timescale 1ns / 1ps

module labf_result_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  labf_pkg::res_push_t  push_i,
  output logic                 room_o,
  labf_kept_if.source          kept_o
);
  import labf_pkg::*;

  kept_t           mem_q [OutDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]   cnt_q, cnt_d;
  logic [PtrW:0]   n_push;
  logic            pop;
  logic [PtrW-1:0] wr_ptr_nxt;

  assign pop        = kept_o.valid && kept_o.ready;
  assign n_push     = (PtrW+1)'(push_i.first_vld) + (PtrW+1)'(push_i.second_vld);
  assign wr_ptr_nxt = wr_ptr_q + PtrW'(1);

  // room for a full two-result point, regardless of this cycle's pop
  assign room_o = (cnt_q <= (PtrW+1)'(OutDepth - 2));

  // pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q + n_push[PtrW-1:0];
    rd_ptr_d = rd_ptr_q + PtrW'(pop);
    cnt_d    = cnt_q + n_push - (PtrW+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push_i.first_vld) begin
      mem_q[wr_ptr_q] <= push_i.first;
    end
    if (push_i.second_vld) begin
      mem_q[wr_ptr_nxt] <= push_i.second;
    end
  end

  // head of queue
  assign kept_o.valid        = (cnt_q != '0);
  assign kept_o.kept_x       = mem_q[rd_ptr_q].kept_x;
  assign kept_o.kept_y       = mem_q[rd_ptr_q].kept_y;
  assign kept_o.kept_bearing = mem_q[rd_ptr_q].kept_bearing;
  assign kept_o.scan_done    = mem_q[rd_ptr_q].scan_done;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PtrW+1)'(OutDepth))
    else $error("result queue overflow");

  a_second_needs_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.second_vld |-> push_i.first_vld)
    else $error("second result without first");

  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.first_vld |-> cnt_q <= (PtrW+1)'(OutDepth - 2))
    else $error("push into a queue without room");

  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    PtrW'(wr_ptr_q - rd_ptr_q) == cnt_q[PtrW-1:0])
    else $error("queue pointers disagree with count");

endmodule

/* src/lidar_angle_bin_min_filter_unit.sv */
// lidar_angle_bin_min_filter_unit: groups consecutive lidar points by angular
// bin and emits the nearest point of each group. Depends on labf_pkg, labf_if,
// labf_cfg_regs and labf_result_fifo.
//
//   channel   dir  type            transfer when
//   point_i   in   labf_point_if   valid & ready
//   kept_o    out  labf_kept_if    valid & ready
//   apb       in   psel/penable    psel & penable & pwrite & pready
//
// One point per cycle. A point is registered at the input, its bin (one
// 15x13 multiply and shift) and the group update are done from the input
// register when the queue has room, and its 0..2 results land in a 4-entry
// result queue whose head drives kept_o. Points stall while a
// point waits in the input register and the queue holds more than two results.
// Reset clears the open group and the queue and sets bins_per_radian to 100.
`timescale 1ns / 1ps

module lidar_angle_bin_min_filter_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  labf_point_if.sink                   point_i,
  labf_kept_if.source                  kept_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [labf_pkg::PaddrW-1:0]  paddr,
  input  logic [labf_pkg::PdataW-1:0]  pwdata,
  output logic [labf_pkg::PdataW-1:0]  prdata,
  output logic                         pready
);
  import labf_pkg::*;

  logic [BprW-1:0]   bpr;
  logic              fifo_room;
  res_push_t         push;

  // input register
  logic              s0_valid_q;
  point_t            s0_q;
  logic              s0_fire;
  logic              in_xfer;

  // group state
  logic              group_open_q;
  bin_t              group_bin_q;
  logic [FieldW-1:0] best_dist_q;
  coord_t            best_x_q, best_y_q, best_bearing_q;

  logic signed [ProdW-1:0] prod;
  logic signed [ProdW-1:0] prod_sh;
  bin_t              s0_bin;
  logic              same_bin;
  logic              take_new;
  logic              emit_close;
  logic [FieldW-1:0] nb_dist;
  coord_t            nb_x, nb_y, nb_bearing;
  kept_t             close_res, flush_res;

  labf_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .bpr_o   (bpr)
  );

  // handshake: input stage drains when the queue has room for two results
  assign s0_fire       = s0_valid_q && fifo_room;
  assign point_i.ready = !s0_valid_q || fifo_room;
  assign in_xfer       = point_i.valid && point_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (point_i.ready) begin
      s0_valid_q <= point_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s0_q.point_x    <= point_i.point_x;
      s0_q.point_y    <= point_i.point_y;
      s0_q.bearing    <= point_i.bearing;
      s0_q.distance   <= point_i.distance;
      s0_q.last_point <= point_i.last_point;
    end
  end

  // bin = floor(bearing * bpr / 2^AngleFracBits), low 16 bits
  assign prod    = ProdW'(s0_q.bearing) * ProdW'($signed({1'b0, bpr}));
  assign prod_sh = prod >>> AngleFracBits;
  assign s0_bin  = prod_sh[BinW-1:0];

  // group decision; strict less-than keeps the first minimum
  assign same_bin   = (s0_bin == group_bin_q);
  assign emit_close = group_open_q && !same_bin;
  assign take_new   = !group_open_q || !same_bin || (s0_q.distance < best_dist_q);

  assign nb_x       = take_new ? s0_q.point_x    : best_x_q;
  assign nb_y       = take_new ? s0_q.point_y    : best_y_q;
  assign nb_bearing = take_new ? s0_q.bearing    : best_bearing_q;
  assign nb_dist    = take_new ? s0_q.distance   : best_dist_q;

  assign close_res = '{kept_x: best_x_q, kept_y: best_y_q,
                       kept_bearing: best_bearing_q, scan_done: 1'b0};
  assign flush_res = '{kept_x: nb_x, kept_y: nb_y,
                       kept_bearing: nb_bearing, scan_done: 1'b1};

  // closed group goes first, then the flush on the last point
  always_comb begin
    push.first_vld  = s0_fire && (emit_close || s0_q.last_point);
    push.second_vld = s0_fire && emit_close && s0_q.last_point;
    push.first      = emit_close ? close_res : flush_res;
    push.second     = flush_res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_open_q <= 1'b0;
    end else if (s0_fire) begin
      group_open_q <= !s0_q.last_point;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s0_fire) begin
      group_bin_q    <= s0_bin;
      best_dist_q    <= nb_dist;
      best_x_q       <= nb_x;
      best_y_q       <= nb_y;
      best_bearing_q <= nb_bearing;
    end
  end

  labf_result_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .room_o (fifo_room),
    .kept_o (kept_o)
  );

  a_last_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s0_fire && s0_q.last_point |=> !group_open_q)
    else $error("group still open after last point");

  a_point_opens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s0_fire && !s0_q.last_point |=> group_open_q)
    else $error("no open group after a non-final point");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s0_valid_q && !fifo_room |=> s0_valid_q && $stable(s0_q))
    else $error("stalled point lost");

  a_flush_marked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.second_vld |-> push.second.scan_done && !push.first.scan_done)
    else $error("result order wrong on bin change at last point");

endmodule
